FILE: rtl/core/tlsu_pkg.sv
// tlsu_pkg: widths, generator constants and the controller-to-datapath command
// bundle for the three-lcg shuffled uniform generator
// no dependencies
package tlsu_pkg;

  // field widths
  localparam int SEED_W = 32;
  localparam int DRAW_W = 36;
  localparam int G_W    = 18;

  // generator one: modulus, multiplier, increment
  localparam int unsigned MOD_A = 259200;
  localparam int unsigned MUL_A = 7141;
  localparam int unsigned ADD_A = 54773;
  // generator two
  localparam int unsigned MOD_B = 134456;
  localparam int unsigned MUL_B = 8121;
  localparam int unsigned ADD_B = 28411;
  // generator three
  localparam int unsigned MOD_C = 243000;
  localparam int unsigned MUL_C = 4561;
  localparam int unsigned ADD_C = 51349;

  // pre-reduction widths: generator one also carries the biased seed word
  localparam int P_A_W  = 33;
  localparam int P_BC_W = 31;

  // 54773 - seed plus the smallest multiple of MOD_A that is at least 2^31,
  // so the floored remainder comes from a non-negative dividend
  localparam longint unsigned SEED_BIAS =
    longint'(ADD_A) + (((64'd1 << 31) + MOD_A - 1) / MOD_A) * MOD_A;

  // registers from a generator value to its reduced next value
  localparam int STEP_LAT = 3;
  localparam int CNT_W    = $clog2(STEP_LAT + 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic cap_seed;   // capture the seed word of the accepted beat
    logic p_seed;     // feed the biased seed into the generator one reducer
    logic ld_g1;      // generator one takes its reduced next value
    logic ld_g2;      // generator two takes its reduced next value
    logic ld_g3;      // generator three takes its reduced next value
    logic g2_red;     // generator two takes generator one mod MOD_B
    logic g3_red;     // generator three takes generator one mod MOD_C
    logic mem_we;     // write the combined value into the shuffle table
    logic slot_sel;   // table access at the selected slot, old entry read out
  } cmd_t;

endpackage

FILE: rtl/core/tlsu_cdiv.sv
// tlsu_cdiv: division of an unsigned word by a constant, reciprocal multiply
// with one correction step; two register stages, corrected result combinational
// no dependencies
module tlsu_cdiv #(
  parameter int NUM_W = 31,
  parameter int DIV   = 259200,
  localparam int R_W  = $clog2(DIV),
  localparam int Q_W  = NUM_W - R_W + 1
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  output logic [Q_W-1:0]   quo,
  output logic [R_W-1:0]   rem
);

  localparam longint unsigned RECIP_L = (64'd1 << NUM_W) / DIV;
  localparam logic [Q_W-1:0]  RECIP   = Q_W'(RECIP_L);

  logic [NUM_W+Q_W-1:0] prod;
  logic [NUM_W-1:0]     diff;
  logic [NUM_W-1:0]     n1;
  logic [Q_W-1:0]       q1;
  logic [Q_W-1:0]       q2;
  logic [R_W:0]         r2;
  logic                 corr;

  // quotient estimate, low by at most one
  assign prod = (NUM_W+Q_W)'(num) * (NUM_W+Q_W)'(RECIP);

  // remainder estimate, below twice the divisor
  assign diff = n1 - NUM_W'(q1) * NUM_W'(DIV);

  always_ff @(posedge clk) begin
    n1 <= num;
    q1 <= prod[NUM_W+Q_W-1:NUM_W];
    q2 <= q1;
    r2 <= diff[R_W:0];
  end

  // final correction
  assign corr = (r2 >= (R_W+1)'(DIV));
  assign rem  = corr ? R_W'(r2 - (R_W+1)'(DIV)) : r2[R_W-1:0];
  assign quo  = q2 + Q_W'(corr);

endmodule

FILE: rtl/core/tlsu_dpath.sv
// tlsu_dpath: generator registers, constant-modulus step units, combiner,
// slot selection and the shuffle table memory
// depends on tlsu_pkg and tlsu_cdiv
module tlsu_dpath #(
  parameter int TABLE_SIZE = 97,
  localparam int ADDR_W    = $clog2(TABLE_SIZE)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tlsu_pkg::cmd_t                  cmd,
  input  logic [ADDR_W-1:0]               waddr,
  input  logic signed [tlsu_pkg::SEED_W-1:0] seed,
  output logic [tlsu_pkg::DRAW_W-1:0]     draw
);

  localparam int SLOT_W   = $clog2(TABLE_SIZE * tlsu_pkg::MOD_C);
  localparam int SLOT_Q_W = SLOT_W - $clog2(tlsu_pkg::MOD_C) + 1;

  logic signed [tlsu_pkg::SEED_W-1:0] seed_q;
  logic [tlsu_pkg::P_A_W-1:0]  seed_u;
  logic [tlsu_pkg::G_W-1:0]    g1;
  logic [tlsu_pkg::G_W-1:0]    g2;
  logic [tlsu_pkg::G_W-1:0]    g3;
  logic [tlsu_pkg::P_A_W-1:0]  p1;
  logic [tlsu_pkg::P_BC_W-1:0] p2;
  logic [tlsu_pkg::P_BC_W-1:0] p3;
  logic [tlsu_pkg::G_W-1:0]    rem_a;
  logic [tlsu_pkg::G_W-1:0]    rem_b;
  logic [tlsu_pkg::G_W-1:0]    rem_c;
  logic [tlsu_pkg::DRAW_W-1:0] comb;
  logic [SLOT_W-1:0]           tval;
  logic [SLOT_Q_W-1:0]         slot_q;
  logic [ADDR_W-1:0]           addr;
  logic [tlsu_pkg::DRAW_W-1:0] mem [TABLE_SIZE];
  logic [tlsu_pkg::DRAW_W-1:0] rd;

  // biased seed, always non-negative
  assign seed_u = tlsu_pkg::P_A_W'(tlsu_pkg::SEED_BIAS) - tlsu_pkg::P_A_W'(seed_q);

  // free-running products ahead of the reducers, combiner and slot scaling
  always_ff @(posedge clk) begin
    if (cmd.cap_seed) begin
      seed_q <= seed;
    end
    p1 <= cmd.p_seed ? seed_u :
          tlsu_pkg::P_A_W'(tlsu_pkg::MUL_A) * tlsu_pkg::P_A_W'(g1) +
          tlsu_pkg::P_A_W'(tlsu_pkg::ADD_A);
    p2 <= tlsu_pkg::P_BC_W'(tlsu_pkg::MUL_B) * tlsu_pkg::P_BC_W'(g2) +
          tlsu_pkg::P_BC_W'(tlsu_pkg::ADD_B);
    p3 <= tlsu_pkg::P_BC_W'(tlsu_pkg::MUL_C) * tlsu_pkg::P_BC_W'(g3) +
          tlsu_pkg::P_BC_W'(tlsu_pkg::ADD_C);
    comb <= tlsu_pkg::DRAW_W'(g1) * tlsu_pkg::DRAW_W'(tlsu_pkg::MOD_B) +
            tlsu_pkg::DRAW_W'(g2);
    tval <= SLOT_W'(TABLE_SIZE) * SLOT_W'(g3);
  end

  // constant-modulus reducers
  tlsu_cdiv #(.NUM_W(tlsu_pkg::P_A_W), .DIV(int'(tlsu_pkg::MOD_A))) u_div_a (
    .clk (clk),
    .num (p1),
    .quo (),
    .rem (rem_a)
  );

  tlsu_cdiv #(.NUM_W(tlsu_pkg::P_BC_W), .DIV(int'(tlsu_pkg::MOD_B))) u_div_b (
    .clk (clk),
    .num (p2),
    .quo (),
    .rem (rem_b)
  );

  tlsu_cdiv #(.NUM_W(tlsu_pkg::P_BC_W), .DIV(int'(tlsu_pkg::MOD_C))) u_div_c (
    .clk (clk),
    .num (p3),
    .quo (),
    .rem (rem_c)
  );

  // slot = table size * g3 / MOD_C
  tlsu_cdiv #(.NUM_W(SLOT_W), .DIV(int'(tlsu_pkg::MOD_C))) u_div_slot (
    .clk (clk),
    .num (tval),
    .quo (slot_q),
    .rem ()
  );

  // generator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      g1 <= '0;
      g2 <= '0;
      g3 <= '0;
    end else begin
      if (cmd.ld_g1) begin
        g1 <= rem_a;
      end
      if (cmd.ld_g2) begin
        g2 <= rem_b;
      end else if (cmd.g2_red) begin
        g2 <= (g1 >= tlsu_pkg::G_W'(tlsu_pkg::MOD_B)) ?
              g1 - tlsu_pkg::G_W'(tlsu_pkg::MOD_B) : g1;
      end
      if (cmd.ld_g3) begin
        g3 <= rem_c;
      end else if (cmd.g3_red) begin
        g3 <= (g1 >= tlsu_pkg::G_W'(tlsu_pkg::MOD_C)) ?
              g1 - tlsu_pkg::G_W'(tlsu_pkg::MOD_C) : g1;
      end
    end
  end

  // shuffle table: old entry read and new value written at the same edge
  assign addr = cmd.slot_sel ? slot_q[ADDR_W-1:0] : waddr;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= comb;
    end
    if (cmd.slot_sel) begin
      rd <= mem[addr];
    end
  end

  assign draw = rd;

endmodule

FILE: rtl/core/tlsu_ctrl.sv
// tlsu_ctrl: request sequencer for reseed, table fill and draw
// depends on tlsu_pkg
module tlsu_ctrl #(
  parameter int TABLE_SIZE = 97,
  localparam int ADDR_W    = $clog2(TABLE_SIZE)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              seed_neg,
  output logic              busy,
  output logic              done,
  output logic              reseeded,
  output tlsu_pkg::cmd_t    cmd,
  output logic [ADDR_W-1:0] waddr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_STEP1,
    S_STEP2,
    S_FILL,
    S_DSTEP,
    S_DSLOT
  } state_t;

  state_t                      state;
  logic [tlsu_pkg::CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0]           idx;
  logic                        wpend;
  logic                        is_seeded;
  logic                        cnt_first;
  logic                        cnt_wb;
  logic                        cnt_last;

  assign cnt_first = (cnt == tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT));
  assign cnt_wb    = (cnt == tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT - 1));
  assign cnt_last  = (cnt == '0);

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.cap_seed = start;
      end
      S_SEED: begin
        cmd.p_seed = 1'b1;
        cmd.ld_g1  = cnt_last;
      end
      S_STEP1: begin
        cmd.ld_g1 = cnt_last;
      end
      S_STEP2: begin
        cmd.g2_red = cnt_first;
        cmd.ld_g1  = cnt_last;
      end
      S_FILL: begin
        cmd.g3_red = cnt_first && (idx == '0);
        cmd.mem_we = wpend && cnt_wb;
        cmd.ld_g1  = cnt_last;
        cmd.ld_g2  = cnt_last;
      end
      S_DSTEP: begin
        cmd.mem_we = wpend && cnt_wb;
        cmd.ld_g1  = cnt_last;
        cmd.ld_g2  = cnt_last;
        cmd.ld_g3  = cnt_last;
      end
      S_DSLOT: begin
        cmd.mem_we   = cnt_last;
        cmd.slot_sel = cnt_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      waddr     <= '0;
      wpend     <= 1'b0;
      is_seeded <= 1'b0;
      busy      <= 1'b0;
      done      <= 1'b0;
      reseeded  <= 1'b0;
    end else begin
      done <= (state == S_DSLOT) && cnt_last;
      if (!cnt_last) begin
        cnt <= cnt - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            wpend <= 1'b0;
            cnt   <= tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT);
            if (seed_neg || !is_seeded) begin
              state     <= S_SEED;
              reseeded  <= 1'b1;
              is_seeded <= 1'b1;
            end else begin
              state    <= S_DSTEP;
              reseeded <= 1'b0;
            end
          end
        end
        S_SEED: begin
          if (cnt_last) begin
            state <= S_STEP1;
            cnt   <= tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT);
          end
        end
        S_STEP1: begin
          if (cnt_last) begin
            state <= S_STEP2;
            cnt   <= tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT);
          end
        end
        S_STEP2: begin
          if (cnt_last) begin
            state <= S_FILL;
            idx   <= '0;
            cnt   <= tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT);
          end
        end
        S_FILL: begin
          // the table write for the previous step is issued during the step after it
          if (wpend && cnt_wb) begin
            wpend <= 1'b0;
          end
          if (cnt_last) begin
            wpend <= 1'b1;
            waddr <= idx;
            cnt   <= tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT);
            if (idx == ADDR_W'(TABLE_SIZE - 1)) begin
              state <= S_DSTEP;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_DSTEP: begin
          if (wpend && cnt_wb) begin
            wpend <= 1'b0;
          end
          if (cnt_last) begin
            state <= S_DSLOT;
            cnt   <= tlsu_pkg::CNT_W'(tlsu_pkg::STEP_LAT);
          end
        end
        S_DSLOT: begin
          if (cnt_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/three_lcg_shuffled_uniform_rng.sv
// three_lcg_shuffled_uniform_rng: top level of the three-lcg shuffled uniform
// generator; joins the sequencer and the datapath
// depends on tlsu_pkg, tlsu_ctrl, tlsu_dpath
//
//  beat      ports                     handshake
//  --------  ------------------------  ---------------------------------
//  request   seed[31:0] signed         taken at an edge with start && !busy
//  result    draw[35:0], reseeded      valid for the one cycle done is high
//
// a draw on a seeded block runs one generator step and then the slot step,
// whose table access comes with the edge that raises done; busy drops with
// done, so the next request is taken at the edge after it. every generator
// step passes a product register and the two stages of the constant-modulus
// reducer. a reseed (negative seed or first request) first adds a seed
// step, two generator steps and one reducer pass per table entry.
// reset is synchronous; the shuffle table holds no reset and is filled by the
// first request. results cannot be stalled.
module three_lcg_shuffled_uniform_rng #(
  parameter int TABLE_SIZE = 97
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tlsu_pkg::SEED_W-1:0] seed,
  output logic                               done,
  output logic [tlsu_pkg::DRAW_W-1:0]        draw,
  output logic                               reseeded
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);

  tlsu_pkg::cmd_t    cmd;
  logic [ADDR_W-1:0] waddr;

  // sequencer
  tlsu_ctrl #(.TABLE_SIZE(TABLE_SIZE)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .seed_neg (seed[tlsu_pkg::SEED_W-1]),
    .busy     (busy),
    .done     (done),
    .reseeded (reseeded),
    .cmd      (cmd),
    .waddr    (waddr)
  );

  // generators, reducers and table
  tlsu_dpath #(.TABLE_SIZE(TABLE_SIZE)) u_dpath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .waddr (waddr),
    .seed  (seed),
    .draw  (draw)
  );

  // a result beat closes exactly one busy period
  a_done_ends_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result beat without a preceding busy period");

  a_busy_fall_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  // the reseed flag is fixed for the whole request
  a_flag_stable : assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> $stable(reseeded))
    else $error("reseed flag changed during a request");

  // no table access outside a request
  a_mem_idle : assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_we || cmd.slot_sel) |-> busy)
    else $error("table access while idle");

endmodule

FILE: tb/shuffle_draw_checker.sv
`timescale 1ns / 100ps
// shuffle_draw_checker: predicts draw and reseed flag of every accepted request beat
// and compares them in order with the result beats of the generator; depends on tlsu_pkg
module shuffle_draw_checker #(
  parameter int TABLE_SIZE = 97
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [tlsu_pkg::SEED_W-1:0] seed,
  input  logic                               done,
  input  logic [tlsu_pkg::DRAW_W-1:0]        draw,
  input  logic                               reseeded,
  output int                                 outstanding,
  output int                                 fail_count
);

  typedef struct packed {
    logic [tlsu_pkg::DRAW_W-1:0] draw;
    logic                        reseeded;
  } draw_beat_t;

  // predicted generator state
  logic [tlsu_pkg::G_W-1:0]    g1, g2, g3;
  logic [tlsu_pkg::DRAW_W-1:0] pool [TABLE_SIZE];
  logic                        seeded;

  draw_beat_t draws_due [$];
  draw_beat_t want, got;
  int         mism = 0;

  function automatic logic [tlsu_pkg::G_W-1:0] lcg_next(
      input logic [tlsu_pkg::G_W-1:0] x,
      input longint unsigned mul,
      input longint unsigned inc,
      input longint unsigned m);
    return tlsu_pkg::G_W'((mul * x + inc) % m);
  endfunction

  function automatic logic [tlsu_pkg::DRAW_W-1:0] mix(input logic [tlsu_pkg::G_W-1:0] a,
                                                      input logic [tlsu_pkg::G_W-1:0] b);
    return tlsu_pkg::DRAW_W'(longint'(a) * tlsu_pkg::MOD_B + b);
  endfunction

  // one request: optional reseed, step all three, swap the selected slot
  task automatic predict_draw(input logic signed [tlsu_pkg::SEED_W-1:0] s,
                              output draw_beat_t res);
    longint t;
    int     slot;
    res.reseeded = s[tlsu_pkg::SEED_W-1] || !seeded;
    if (res.reseeded) begin
      // floored remainder so every seed word lands in 0..MOD_A-1
      t = (longint'(tlsu_pkg::ADD_A) - longint'(s)) % longint'(tlsu_pkg::MOD_A);
      if (t < 0) t += longint'(tlsu_pkg::MOD_A);
      g1 = lcg_next(tlsu_pkg::G_W'(t), tlsu_pkg::MUL_A, tlsu_pkg::ADD_A, tlsu_pkg::MOD_A);
      g2 = tlsu_pkg::G_W'(g1 % tlsu_pkg::MOD_B);
      g1 = lcg_next(g1, tlsu_pkg::MUL_A, tlsu_pkg::ADD_A, tlsu_pkg::MOD_A);
      g3 = tlsu_pkg::G_W'(g1 % tlsu_pkg::MOD_C);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        g1 = lcg_next(g1, tlsu_pkg::MUL_A, tlsu_pkg::ADD_A, tlsu_pkg::MOD_A);
        g2 = lcg_next(g2, tlsu_pkg::MUL_B, tlsu_pkg::ADD_B, tlsu_pkg::MOD_B);
        pool[i] = mix(g1, g2);
      end
      seeded = 1'b1;
    end
    g1 = lcg_next(g1, tlsu_pkg::MUL_A, tlsu_pkg::ADD_A, tlsu_pkg::MOD_A);
    g2 = lcg_next(g2, tlsu_pkg::MUL_B, tlsu_pkg::ADD_B, tlsu_pkg::MOD_B);
    g3 = lcg_next(g3, tlsu_pkg::MUL_C, tlsu_pkg::ADD_C, tlsu_pkg::MOD_C);
    slot = int'((longint'(TABLE_SIZE) * g3) / tlsu_pkg::MOD_C);
    if (slot >= TABLE_SIZE) slot = TABLE_SIZE - 1;
    res.draw = pool[slot];
    pool[slot] = mix(g1, g2);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      g1 = '0;
      g2 = '0;
      g3 = '0;
      seeded = 1'b0;
      draws_due.delete();
    end else begin
      // result beat against the oldest prediction
      if (done) begin
        if (draws_due.size() == 0) begin
          mism++;
          if (mism < 30)
            $display("%0t: draw beat with none expected: expected none actual %h/%b",
                     $time, draw, reseeded);
        end else begin
          want = draws_due.pop_front();
          if (draw !== want.draw) begin
            mism++;
            if (mism < 30)
              $display("%0t: draw mismatch: expected %h actual %h", $time, want.draw, draw);
          end
          if (reseeded !== want.reseeded) begin
            mism++;
            if (mism < 30)
              $display("%0t: reseeded mismatch: expected %b actual %b",
                       $time, want.reseeded, reseeded);
          end
        end
      end
      // request beat taken at this edge
      if (start && !busy) begin
        predict_draw(seed, got);
        draws_due.push_back(got);
      end
    end
    outstanding <= draws_due.size();
    fail_count  <= mism;
  end

endmodule

FILE: tb/three_lcg_shuffled_uniform_rng_tb.sv
`timescale 1ns / 100ps
// three_lcg_shuffled_uniform_rng_tb: directed and random seed requests under several
// idle patterns; depends on tlsu_pkg, three_lcg_shuffled_uniform_rng, shuffle_draw_checker
module three_lcg_shuffled_uniform_rng_tb;

  localparam int CYCLE_LIMIT      = 2000000;
  localparam int TAIL_CYCLES      = 450;
  localparam int RANDOM_PER_PHASE = 210;

  logic                               clk   = 1'b0;
  logic                               rst   = 1'b1;
  logic                               start = 1'b0;
  logic signed [tlsu_pkg::SEED_W-1:0] seed  = '0;
  logic                               busy, done, reseeded;
  logic [tlsu_pkg::DRAW_W-1:0]        draw;
  int                                 outstanding, fail_count;
  int                                 cycles = 0;

  // sender idle percentage per phase
  int idle_pct [4] = '{0, 64, 0, 31};

  // first beat reseeds on a positive seed with a negative remainder; then ignored
  // positives, both sign extremes, remainders landing on zero, small negatives
  logic signed [tlsu_pkg::SEED_W-1:0] corner_seeds [16] = '{
    32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF,
    32'sh5555_5555, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
    32'shAAAA_AAAA, -32'sd204427,   32'sd54773,     -32'sd463627,
    -32'sd2,        32'sh0000_0002, 32'sh8000_0001, 32'sh0000_0000
  };

  three_lcg_shuffled_uniform_rng uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .seed     (seed),
    .done     (done),
    .draw     (draw),
    .reseeded (reseeded)
  );

  shuffle_draw_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .seed        (seed),
    .done        (done),
    .draw        (draw),
    .reseeded    (reseeded),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #2 clk = ~clk;

  // mostly plain draws, some full-range and some near-zero reseeds
  function automatic logic [tlsu_pkg::SEED_W-1:0] random_seed();
    logic [tlsu_pkg::SEED_W-1:0] w;
    int unsigned                 pick;
    w = $urandom();
    pick = $urandom_range(99);
    if (pick < 10) w[tlsu_pkg::SEED_W-1] = 1'b1;
    else if (pick < 14) w = -tlsu_pkg::SEED_W'($urandom_range(300000, 1));
    else w[tlsu_pkg::SEED_W-1] = 1'b0;
    return w;
  endfunction

  // one request beat, after a random number of idle cycles
  task automatic issue(input logic [tlsu_pkg::SEED_W-1:0] s, input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    seed  <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every predicted draw has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed beats
    foreach (corner_seeds[i]) issue(corner_seeds[i], 0);
    wait_drained();
    // random phases, drained in between
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) issue(random_seed(), idle_pct[ph]);
      wait_drained();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tlsu_pkg.sv
rtl/core/tlsu_cdiv.sv
rtl/core/tlsu_dpath.sv
rtl/core/tlsu_ctrl.sv
rtl/core/three_lcg_shuffled_uniform_rng.sv
tb/shuffle_draw_checker.sv
tb/three_lcg_shuffled_uniform_rng_tb.sv
